@@ sv/frm_pkg.sv @@
// ---------------------------------------------------------------------------
// frm_pkg: shared types, widths and tables of the frame rate meter
// Field widths, divider sizing, register map and the seven-segment decoder.
// ---------------------------------------------------------------------------
package frm_pkg;

	localparam int TIME_W    = 48;
	localparam int CNT_W     = 32;
	localparam int PER_W     = 32;
	localparam int RATE_W    = 14;
	localparam int FT_W      = 48;
	localparam int DIG_W     = 4;
	localparam int SEG_W     = 7;
	localparam int DCNT_W    = 3;
	localparam int NUM_DIGITS = 4;
	localparam int BCD_W     = DIG_W * NUM_DIGITS;
	localparam int US_W      = 20;

	localparam logic [US_W-1:0]   US_PER_SEC   = 20'd1000000;
	localparam logic [RATE_W-1:0] RATE_MAX     = 14'd9999;
	localparam logic [PER_W-1:0]  PERIOD_RESET = 32'd2000000;

	// divider: dividend holds either the elapsed time or frames * 1e6
	localparam int PROD_W    = CNT_W + US_W;
	localparam int NUM_W     = (PROD_W > TIME_W) ? PROD_W : TIME_W;
	localparam int DEN_W     = (CNT_W > PER_W) ? CNT_W : PER_W;
	localparam int DIV_CNT_W = $clog2(NUM_W + 1);
	localparam int BCD_CNT_W = $clog2(RATE_W + 1);

	// register map: one register, word index taken from paddr[2]
	localparam int ADDR_W   = 3;
	localparam int ADDR_IDX = 2;
	localparam logic REG_PERIOD = 1'b0;

	// stream payload layout
	localparam int IN_TDATA_W  = ((TIME_W + 7) / 8) * 8;
	localparam int OUT_BITS    = RATE_W + FT_W + DCNT_W + BCD_W + SEG_W * NUM_DIGITS;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CMP   = 6'b000010,
		ST_DIV_T = 6'b000100,
		ST_DIV_R = 6'b001000,
		ST_BCD   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	// bit0 top, tl, tr, center, bl, br, bit6 bottom
	function automatic logic [SEG_W-1:0] seg7(input logic [DIG_W-1:0] d);
		logic [SEG_W-1:0] s;
		unique case (d)
			4'd0:    s = 7'd119;
			4'd1:    s = 7'd36;
			4'd2:    s = 7'd93;
			4'd3:    s = 7'd109;
			4'd4:    s = 7'd46;
			4'd5:    s = 7'd107;
			4'd6:    s = 7'd123;
			4'd7:    s = 7'd37;
			4'd8:    s = 7'd127;
			4'd9:    s = 7'd111;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

@@ sv/frm_div.sv @@
// ---------------------------------------------------------------------------
// frm_div: bit-serial restoring divider
// One quotient bit per cycle, MSB first; done pulses when the quotient is final.
// ---------------------------------------------------------------------------
module frm_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [frm_pkg::NUM_W-1:0] num,
	input  logic [frm_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [frm_pkg::NUM_W-1:0] quo
);
	import frm_pkg::*;

	logic [NUM_W-1:0]     quo_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DEN_W:0]       part;
	logic [DEN_W:0]       diff;
	logic                 ge;

	// shift in the next dividend bit, subtract where it fits
	assign part = {rem_q, quo_q[NUM_W-1]};
	assign ge   = part >= {1'b0, den_q};
	assign diff = part - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == DIV_CNT_W'(NUM_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(NUM_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

@@ sv/frame_rate_meter_bcd.sv @@
// ---------------------------------------------------------------------------
// frame_rate_meter_bcd: frame rate meter with four-digit seven-segment readout
// Counts frame events, closes a measurement window after update_period us,
// and shows the held rate as decimal digits with segment masks.
// ---------------------------------------------------------------------------
// Path: a beat that leaves the window open goes through ST_CMP and ST_OUT into
//   the output register; a beat that closes the window also takes two passes
//   of the 52-bit bit-serial divider (a zero period skips the rate pass) and
//   the 14-step binary-to-BCD shifter before ST_OUT.
// Flow: one beat in flight at a time; the next beat is taken while the previous
//   result waits in the output register.
// Reset: arst_n clears window, count, held rate and frame time; period = 2e6.
module frame_rate_meter_bcd (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [frm_pkg::IN_TDATA_W-1:0]  s_tdata,   // current_time
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// frame_rate, frame_time, digit_count, digit_ones, digit_tens,
	// digit_hundreds, digit_thousands, segments_ones, segments_tens,
	// segments_hundreds, segments_thousands, zero pad
	output logic [frm_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                            m_tuser,   // updated
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [frm_pkg::ADDR_W-1:0]      paddr,
	input  logic [frm_pkg::PER_W-1:0]       pwdata,
	output logic [frm_pkg::PER_W-1:0]       prdata,
	output logic                            pready
);
	import frm_pkg::*;

	state_t               state_q;
	logic [PER_W-1:0]     period_q;
	logic [TIME_W-1:0]    win_start_q;
	logic [CNT_W-1:0]     frames_q;
	logic [TIME_W-1:0]    now_q;
	logic [TIME_W-1:0]    elapsed_q;
	logic [PROD_W-1:0]    prod_q;
	logic [FT_W-1:0]      held_ft_q;
	logic [RATE_W-1:0]    held_rate_q;
	logic [BCD_W-1:0]     dig_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [RATE_W-1:0]    bin_q;
	logic [BCD_CNT_W-1:0] bcd_cnt_q;
	logic                 upd_q;

	logic                 out_valid_q;
	logic                 out_upd_q;
	logic [RATE_W-1:0]    out_rate_q;
	logic [FT_W-1:0]      out_ft_q;
	logic [BCD_W-1:0]     out_dig_q;

	logic                 in_beat;
	logic                 cfg_wr;
	logic                 close_win;
	logic                 out_free;
	logic                 div_start;
	logic [NUM_W-1:0]     div_num;
	logic [DEN_W-1:0]     div_den;
	logic                 div_done;
	logic [NUM_W-1:0]     div_quo;
	logic [RATE_W-1:0]    rate_clamped;
	logic [BCD_W-1:0]     bcd_adj;
	logic [BCD_W-1:0]     bcd_next;
	logic [DCNT_W-1:0]    digit_count;
	logic [DIG_W-1:0]     d_ones, d_tens, d_hund, d_thou;

	// ---------------------------------------------------------------------
	// handshakes
	// ---------------------------------------------------------------------
	assign s_tready = (state_q == ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready && (paddr[ADDR_IDX] == REG_PERIOD);
	assign prdata   = (paddr[ADDR_IDX] == REG_PERIOD) ? period_q : '0;

	// strictly longer than the period closes the window
	assign close_win = elapsed_q > TIME_W'(period_q);

	// ---------------------------------------------------------------------
	// shared divider: frame time first, then frames * 1e6 / period
	// ---------------------------------------------------------------------
	always_comb begin
		div_start = 1'b0;
		div_num   = NUM_W'(prod_q);
		div_den   = DEN_W'(period_q);
		if (state_q == ST_CMP && close_win) begin
			div_start = 1'b1;
			div_num   = NUM_W'(elapsed_q);
			div_den   = DEN_W'(frames_q);
		end else if (state_q == ST_DIV_T && div_done && period_q != '0) begin
			div_start = 1'b1;
		end
	end

	frm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// anything above the display range shows as 9999
	assign rate_clamped = (div_quo > NUM_W'(RATE_MAX)) ? RATE_MAX : div_quo[RATE_W-1:0];

	// ---------------------------------------------------------------------
	// double dabble: add 3 to every digit at five or more, then shift in
	// the next rate bit, MSB first
	// ---------------------------------------------------------------------
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[i*DIG_W +: DIG_W] >= DIG_W'(5))
				bcd_adj[i*DIG_W +: DIG_W] = bcd_q[i*DIG_W +: DIG_W] + DIG_W'(3);
			else
				bcd_adj[i*DIG_W +: DIG_W] = bcd_q[i*DIG_W +: DIG_W];
		end
	end
	assign bcd_next = {bcd_adj[BCD_W-2:0], bin_q[RATE_W-1]};

	// ---------------------------------------------------------------------
	// control
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			period_q    <= PERIOD_RESET;
			win_start_q <= '0;
			frames_q    <= '0;
			held_ft_q   <= '0;
			held_rate_q <= '0;
			dig_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr)
				period_q <= pwdata;

			// load a new result, or drop the one just taken
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						// count this frame first, saturating
						if (frames_q != '1)
							frames_q <= frames_q + 1'b1;
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (close_win) begin
						frames_q    <= '0;
						win_start_q <= now_q;
						state_q     <= ST_DIV_T;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_DIV_T: begin
					if (div_done) begin
						held_ft_q <= div_quo[FT_W-1:0];
						if (period_q == '0) begin
							// no window length: rate pins to the top
							held_rate_q <= RATE_MAX;
							state_q     <= ST_BCD;
						end else begin
							state_q <= ST_DIV_R;
						end
					end
				end
				ST_DIV_R: begin
					if (div_done) begin
						held_rate_q <= rate_clamped;
						state_q     <= ST_BCD;
					end
				end
				ST_BCD: begin
					if (bcd_cnt_q == BCD_CNT_W'(RATE_W - 1)) begin
						dig_q   <= bcd_next;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the output register is free
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// datapath registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_beat) begin
			now_q     <= s_tdata[TIME_W-1:0];
			// wraps modulo 2^TIME_W
			elapsed_q <= s_tdata[TIME_W-1:0] - win_start_q;
		end
		if (state_q == ST_CMP) begin
			upd_q  <= close_win;
			prod_q <= frames_q * US_PER_SEC;
		end
		// load the BCD shifter with whichever rate is being held
		if (state_q == ST_DIV_T && div_done && period_q == '0) begin
			bin_q     <= RATE_MAX;
			bcd_q     <= '0;
			bcd_cnt_q <= '0;
		end else if (state_q == ST_DIV_R && div_done) begin
			bin_q     <= rate_clamped;
			bcd_q     <= '0;
			bcd_cnt_q <= '0;
		end else if (state_q == ST_BCD) begin
			bin_q     <= {bin_q[RATE_W-2:0], 1'b0};
			bcd_q     <= bcd_next;
			bcd_cnt_q <= bcd_cnt_q + 1'b1;
		end
		if (state_q == ST_OUT && out_free) begin
			out_upd_q  <= upd_q;
			out_rate_q <= held_rate_q;
			out_ft_q   <= held_ft_q;
			out_dig_q  <= dig_q;
		end
	end

	// ---------------------------------------------------------------------
	// readout: digits, blanking count, segment masks
	// ---------------------------------------------------------------------
	assign d_ones = out_dig_q[0*DIG_W +: DIG_W];
	assign d_tens = out_dig_q[1*DIG_W +: DIG_W];
	assign d_hund = out_dig_q[2*DIG_W +: DIG_W];
	assign d_thou = out_dig_q[3*DIG_W +: DIG_W];

	// drop leading zeros, always keep the ones digit
	always_comb begin
		if (d_thou != '0)
			digit_count = DCNT_W'(4);
		else if (d_hund != '0)
			digit_count = DCNT_W'(3);
		else if (d_tens != '0)
			digit_count = DCNT_W'(2);
		else
			digit_count = DCNT_W'(1);
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_upd_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}},
		seg7(d_thou), seg7(d_hund), seg7(d_tens), seg7(d_ones),
		d_thou, d_hund, d_tens, d_ones,
		digit_count, out_ft_q, out_rate_q};

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_accept_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q == ST_CMP))
		else $error("accepted beat did not move to compare");

	a_rate_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_rate_q <= RATE_MAX)
		else $error("held rate above display range");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP && close_win) |=> (frames_q == '0 && state_q == ST_DIV_T))
		else $error("window close did not clear the frame count");

	a_out_digits: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (d_ones <= DIG_W'(9) && d_tens <= DIG_W'(9) &&
		d_hund <= DIG_W'(9) && d_thou <= DIG_W'(9)))
		else $error("output digit not decimal");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the frame rate meter
// Streams frame timestamps into the meter, tracks windows, rate, frame time
// and the four-digit readout in a local model, and compares every result
// beat field by field. The window period is changed between phases over APB.
// ---------------------------------------------------------------------------
module tb_top;
	import frm_pkg::*;

	// result layout in m_tdata, lowest bit first
	localparam int OFS_RATE = 0;
	localparam int OFS_FT   = OFS_RATE + RATE_W;
	localparam int OFS_DCNT = OFS_FT + FT_W;
	localparam int OFS_DIG  = OFS_DCNT + DCNT_W;
	localparam int OFS_SEG  = OFS_DIG + BCD_W;

	localparam logic [ADDR_W-1:0] PERIOD_ADDR = ADDR_W'(4 * REG_PERIOD);
	localparam int DRAIN_WAIT = 150;
	localparam int PHASES     = 9;
	localparam int PHASE_LEN  = 200;

	// segment masks per decimal digit: bit0 top ... bit6 bottom
	localparam logic [SEG_W-1:0] SEG_LUT [10] = '{
		7'd119, 7'd36, 7'd93, 7'd109, 7'd46, 7'd107, 7'd123, 7'd37, 7'd127, 7'd111
	};

	typedef struct packed {
		logic                             upd;
		logic [RATE_W-1:0]                rate;
		logic [FT_W-1:0]                  ftime;
		logic [DCNT_W-1:0]                ndig;
		logic [NUM_DIGITS-1:0][DIG_W-1:0] dig;
		logic [NUM_DIGITS-1:0][SEG_W-1:0] seg;
	} readout_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   psel     = 1'b0;
	logic                   penable  = 1'b0;
	logic                   pwrite   = 1'b0;
	logic [ADDR_W-1:0]      paddr    = '0;
	logic [PER_W-1:0]       pwdata   = '0;
	logic [PER_W-1:0]       prdata;
	logic                   pready;

	// meter model state, starts at its reset values
	logic [TIME_W-1:0] win_start  = '0;
	logic [CNT_W-1:0]  win_frames = '0;
	logic [RATE_W-1:0] held_rate  = '0;
	logic [FT_W-1:0]   held_ftime = '0;
	logic [PER_W-1:0]  period_reg = PERIOD_RESET;

	logic [TIME_W-1:0] frame_q [$];    // timestamps waiting to be sent
	readout_t          readout_q [$];  // readouts waiting on the result side
	int                errs = 0;
	logic              calm = 1'b0;    // no idling on either side while set
	string             dig_name [4] = '{"digit_ones", "digit_tens",
		"digit_hundreds", "digit_thousands"};
	string             seg_name [4] = '{"segments_ones", "segments_tens",
		"segments_hundreds", "segments_thousands"};

	frame_rate_meter_bcd u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	// Count one frame, close the window when the elapsed time is strictly
	// past the period, and return the readout of the held rate.
	function automatic readout_t meter_frame(input logic [TIME_W-1:0] now);
		readout_t          ro;
		logic [TIME_W-1:0] elapsed;
		logic [63:0]       scaled;
		int unsigned       r;
		ro = '0;
		// saturate the frame count
		if (win_frames != '1)
			win_frames = win_frames + 1'b1;
		// wraps modulo 2^TIME_W
		elapsed = now - win_start;
		if (elapsed > TIME_W'(period_reg)) begin
			held_ftime = elapsed / TIME_W'(win_frames);
			if (period_reg == '0) begin
				held_rate = RATE_MAX;
			end else begin
				scaled = 64'(win_frames) * 64'(US_PER_SEC) / 64'(period_reg);
				held_rate = (scaled > 64'(RATE_MAX)) ? RATE_MAX : scaled[RATE_W-1:0];
			end
			win_frames = '0;
			win_start  = now;
			ro.upd     = 1'b1;
		end
		r        = held_rate;
		ro.rate  = held_rate;
		ro.ftime = held_ftime;
		ro.dig[0] = DIG_W'(r % 10);
		ro.dig[1] = DIG_W'((r / 10) % 10);
		ro.dig[2] = DIG_W'((r / 100) % 10);
		ro.dig[3] = DIG_W'((r / 1000) % 10);
		for (int i = 0; i < NUM_DIGITS; i++)
			ro.seg[i] = SEG_LUT[ro.dig[i]];
		// blank leading zeros, always keep the ones digit
		if (ro.dig[3] != 0)
			ro.ndig = 3'd4;
		else if (ro.dig[2] != 0)
			ro.ndig = 3'd3;
		else if (ro.dig[1] != 0)
			ro.ndig = 3'd2;
		else
			ro.ndig = 3'd1;
		return ro;
	endfunction

	// Mostly short gaps, a few long ones.
	function automatic int draw_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 100);
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errs++;
		end
	endtask

	// ---------------------------------------------------------------------
	// Input driver: take timestamps from frame_q, predict at acceptance.
	// ---------------------------------------------------------------------
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin : drv
		logic fire;
		int   g;
		logic vld_n;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left = 0;
		end else begin
			fire  = s_tvalid && s_tready;
			g     = gap_left;
			vld_n = s_tvalid;
			if (fire) begin
				readout_q.push_back(meter_frame(s_tdata[TIME_W-1:0]));
				g = (calm || $urandom_range(0, 99) < 55) ? 0 : draw_idle();
			end
			// hold a beat that is still waiting for tready
			if (s_tvalid && !fire) begin
				vld_n = 1'b1;
			end else if (g > 0) begin
				g--;
				vld_n = 1'b0;
			end else if (frame_q.size() != 0) begin
				vld_n = 1'b1;
				s_tdata <= IN_TDATA_W'(frame_q.pop_front());
			end else begin
				vld_n = 1'b0;
			end
			gap_left = g;
			s_tvalid <= vld_n;
		end
	end

	// ---------------------------------------------------------------------
	// Result monitor: compare each beat with the oldest readout, drive
	// random back-pressure.
	// ---------------------------------------------------------------------
	int stall_left = 0;

	always @(posedge clk or negedge arst_n) begin : mon
		readout_t want;
		readout_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.upd   = m_tuser;
				got.rate  = m_tdata[OFS_RATE +: RATE_W];
				got.ftime = m_tdata[OFS_FT +: FT_W];
				got.ndig  = m_tdata[OFS_DCNT +: DCNT_W];
				got.dig   = m_tdata[OFS_DIG +: BCD_W];
				got.seg   = m_tdata[OFS_SEG +: SEG_W * NUM_DIGITS];
				if (readout_q.size() == 0) begin
					$error("result beat with no readout pending");
					errs++;
				end else begin
					want = readout_q.pop_front();
					check_field("updated", 64'(want.upd), 64'(got.upd));
					check_field("frame_rate", 64'(want.rate), 64'(got.rate));
					check_field("frame_time", 64'(want.ftime), 64'(got.ftime));
					check_field("digit_count", 64'(want.ndig), 64'(got.ndig));
					for (int i = 0; i < NUM_DIGITS; i++) begin
						check_field(dig_name[i], 64'(want.dig[i]), 64'(got.dig[i]));
						check_field(seg_name[i], 64'(want.seg[i]), 64'(got.seg[i]));
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < 15) begin
				stall_left = draw_idle() - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	logic [TIME_W-1:0] t_now = '0;

	task automatic send(input logic [TIME_W-1:0] t);
		frame_q.push_back(t);
		t_now = t;
	endtask

	// Block until every queued frame went out and every readout came back.
	task automatic drain();
		@(negedge clk);
		while (frame_q.size() != 0 || s_tvalid || readout_q.size() != 0)
			@(negedge clk);
	endtask

	// Write the period, then read it back. Call only while the meter is idle.
	task automatic set_period(input logic [PER_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PERIOD_ADDR;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		period_reg = val;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		check_field("prdata", 64'(val), 64'(prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [TIME_W-1:0] rand_time();
		return {16'($urandom), 32'($urandom)};
	endfunction

	initial begin : stim
		logic [PER_W-1:0] per;
		int unsigned      span;
		int               r;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset period, equal versus strictly greater elapsed time
		send(48'd0);
		send(48'd2000000);
		send(48'd2000001);
		send(48'd2000001);
		send(48'd4000002);
		// a jump to the top of the timestamp range gives a huge elapsed time, then wrap forward
		send('1);
		send(48'd5);
		send(48'd2000001);
		drain();

		// period of 1: the rate clamps
		set_period(32'd1);
		send(t_now + 48'd1);
		send(t_now + 48'd1);
		drain();

		// longest period, huge elapsed times
		set_period(32'hFFFF_FFFF);
		send(t_now + 48'h1_0000_0000);
		send(t_now + 48'h8000_0000_0000);
		drain();

		// rate 1001: zeros inside the number
		set_period(32'd999);
		send(t_now + 48'd1000);
		drain();
		// rate 30: two digits shown
		set_period(32'd100000);
		send(t_now + 48'd40000);
		send(t_now + 48'd40000);
		send(t_now + 48'd20001);
		drain();
		// rate 100: three digits shown
		set_period(32'd10000);
		send(t_now + 48'd10001);
		send(t_now + 48'd5000);
		drain();

		// random phases, each with its own period and frame spacing
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case ($urandom_range(0, 5))
				0:       per = 32'd1;
				1:       per = 32'hFFFF_FFFF;
				2:       per = $urandom_range(2, 1000);
				3:       per = $urandom_range(1000, 5000000);
				4:       per = ($urandom == 0) ? 32'd1 : $urandom;
				default: per = PERIOD_RESET;
			endcase
			set_period(per);
			calm <= ($urandom_range(0, 3) == 0);
			span = 32'd1 << $urandom_range(0, 30);
			// sometimes start just below the wrap point of the timestamp
			if ($urandom_range(0, 2) == 0)
				t_now = '1 - TIME_W'($urandom_range(0, 1 << 20));
			for (int k = 0; k < PHASE_LEN; k++) begin
				r = $urandom_range(0, 99);
				if (r < 90)
					send(t_now + TIME_W'($urandom_range(0, span) * 2));
				else if (r < 95)
					send(rand_time());
				else
					send(t_now - TIME_W'($urandom_range(1, 1000)));
				// halt the sender once mid-phase until the meter is empty
				if (ph == 0 && k == PHASE_LEN / 2)
					drain();
			end
		end

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errs == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin : watchdog
		#(10_000_000);
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
